FILE: hw/rtl/trsmc_pkg.sv
// Shared widths, types, term indexes and helpers for the TRS matrix compose block.
package trsmc_pkg;

    localparam int QUAT_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = 2 * QUAT_W;
    localparam int NUM_AXES   = 3;
    localparam int NUM_TERMS  = 9;
    localparam int NUM_STAGES = 4;

    localparam int QUAT_FRAC_DEF  = 14;
    localparam int SCALE_FRAC_DEF = 8;
    localparam int OUT_FRAC_DEF   = 16;

    // Positions of the nine rotation terms, basis column by basis column.
    localparam int IDX_XAXIS_X = 0;
    localparam int IDX_XAXIS_Y = 1;
    localparam int IDX_XAXIS_Z = 2;
    localparam int IDX_YAXIS_X = 3;
    localparam int IDX_YAXIS_Y = 4;
    localparam int IDX_YAXIS_Z = 5;
    localparam int IDX_ZAXIS_X = 6;
    localparam int IDX_ZAXIS_Y = 7;
    localparam int IDX_ZAXIS_Z = 8;

    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [VAL_W-1:0]  val_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] wz;
    } quat_prod_t;

    typedef struct packed {
        logic signed [SCALE_W-1:0] x;
        logic signed [SCALE_W-1:0] y;
        logic signed [SCALE_W-1:0] z;
    } scale_vec_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } val_vec_t;

    // Width of a rotation term: it must hold 1.0 at 2*qf fraction bits and
    // twice a sum of two full-range quaternion products, plus a sign bit.
    function automatic int term_width(input int qf);
        int w;
        begin
            w = 2 * qf + 3;
            term_width = (w > 35) ? w : 35;
        end
    endfunction

endpackage

FILE: hw/rtl/trs_matrix_compose_top.sv
// Top level of the TRS matrix compose block: handshake control and the four pipeline stages.
//
// Usage: each input word carries a translation (Q16.16), a rotation quaternion
// (signed, QUAT_FRAC_BITS fraction bits, used as given and never normalized) and
// a per-axis scale (signed, SCALE_FRAC_BITS fraction bits). Each word yields one
// output word holding the twelve upper entries of the column-major 4x4 transform:
// three scaled basis columns, rounded half away from zero and saturated to
// 32 bits, and the translation passed through unchanged.
// Both channels use valid and stall; a word moves on a clock edge where valid is
// high and stall is low.
// A word passes through the four register stages in order (quaternion products,
// rotation terms, scale multiply, round and saturate), which take one word per
// cycle while the receiver does not stall, so sustained throughput is one word a cycle.
// When the receiver stalls, the output word holds and the stages behind it keep
// filling until each holds a word; in_stall rises only when all four are full
// and the output is stalled. Empty stages are closed up, so no bubble is kept.
// Reset (rst_n low, asynchronous) empties every stage; the data registers are not reset.
module trs_matrix_compose_top
    import trsmc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS  = QUAT_FRAC_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,

    input  logic  in_valid,
    output logic  in_stall,
    input  val_t  trans_x,
    input  val_t  trans_y,
    input  val_t  trans_z,
    input  quat_t quat_x,
    input  quat_t quat_y,
    input  quat_t quat_z,
    input  quat_t quat_w,
    input  logic signed [SCALE_W-1:0] scale_x,
    input  logic signed [SCALE_W-1:0] scale_y,
    input  logic signed [SCALE_W-1:0] scale_z,

    output logic  out_valid,
    input  logic  out_stall,
    output val_t  xaxis_x,
    output val_t  xaxis_y,
    output val_t  xaxis_z,
    output val_t  yaxis_x,
    output val_t  yaxis_y,
    output val_t  yaxis_z,
    output val_t  zaxis_x,
    output val_t  zaxis_y,
    output val_t  zaxis_z,
    output val_t  origin_x,
    output val_t  origin_y,
    output val_t  origin_z
);

    localparam int TW = term_width(QUAT_FRAC_BITS);
    localparam int PW = TW + SCALE_W;

    // One valid bit per stage; a stage may load when it is empty or when the
    // stage after it is moving on.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] rdy;
    logic [NUM_STAGES-1:0] ld;

    always_comb
    begin
        rdy[NUM_STAGES-1] = ~vld_reg[NUM_STAGES-1] | ~out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = ~vld_reg[k] | rdy[k+1];
        end
        ld[0] = rdy[0] & in_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            ld[k] = rdy[k] & vld_reg[k-1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = ~rdy[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    // Input side data gathered into the shared vector types.
    scale_vec_t scale_in;
    val_vec_t   trans_in;

    assign scale_in.x = scale_x;
    assign scale_in.y = scale_y;
    assign scale_in.z = scale_z;
    assign trans_in.x = trans_x;
    assign trans_in.y = trans_y;
    assign trans_in.z = trans_z;

    // Stage 1: quaternion products.
    quat_prod_t s1_prod;
    scale_vec_t s1_scale;
    val_vec_t   s1_trans;

    trsmc_quat_prod u_quat_prod (
        .clk       (clk),
        .en        (ld[0]),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .scale_in  (scale_in),
        .trans_in  (trans_in),
        .prod_reg  (s1_prod),
        .scale_reg (s1_scale),
        .trans_reg (s1_trans)
    );

    // Stage 2: rotation terms at 2*QUAT_FRAC_BITS fraction bits.
    logic signed [TW-1:0] s2_term [NUM_TERMS];
    scale_vec_t           s2_scale;
    val_vec_t             s2_trans;

    trsmc_term #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_term (
        .clk       (clk),
        .en        (ld[1]),
        .prod      (s1_prod),
        .scale_in  (s1_scale),
        .trans_in  (s1_trans),
        .term_reg  (s2_term),
        .scale_reg (s2_scale),
        .trans_reg (s2_trans)
    );

    // Stage 3: exact products with the axis scales.
    logic signed [PW-1:0] s3_prod [NUM_TERMS];
    val_vec_t             s3_trans;

    trsmc_scale_mul #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_scale_mul (
        .clk       (clk),
        .en        (ld[2]),
        .term      (s2_term),
        .scale_in  (s2_scale),
        .trans_in  (s2_trans),
        .prod_reg  (s3_prod),
        .trans_reg (s3_trans)
    );

    // Stage 4: rounding and saturation; these registers are the output word.
    val_t     s4_res [NUM_TERMS];
    val_vec_t s4_trans;

    trsmc_round_sat #(
        .QUAT_FRAC_BITS  (QUAT_FRAC_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
        .OUT_FRAC_BITS   (OUT_FRAC_BITS)
    ) u_round_sat (
        .clk       (clk),
        .en        (ld[3]),
        .prod      (s3_prod),
        .trans_in  (s3_trans),
        .res_reg   (s4_res),
        .trans_reg (s4_trans)
    );

    assign xaxis_x  = s4_res[IDX_XAXIS_X];
    assign xaxis_y  = s4_res[IDX_XAXIS_Y];
    assign xaxis_z  = s4_res[IDX_XAXIS_Z];
    assign yaxis_x  = s4_res[IDX_YAXIS_X];
    assign yaxis_y  = s4_res[IDX_YAXIS_Y];
    assign yaxis_z  = s4_res[IDX_YAXIS_Z];
    assign zaxis_x  = s4_res[IDX_ZAXIS_X];
    assign zaxis_y  = s4_res[IDX_ZAXIS_Y];
    assign zaxis_z  = s4_res[IDX_ZAXIS_Z];
    assign origin_x = s4_trans.x;
    assign origin_y = s4_trans.y;
    assign origin_z = s4_trans.z;

    // The input is held off only when every stage is full and the output is stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // A word accepted while the output keeps flowing moves through every stage
    // without being held and is then waiting at the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            |=> out_valid)
        else $error("accepted word did not reach the output in four cycles");

    // The x and z translation components travel with their word through all stages.
    a_origin_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            |=> (origin_x == $past(trans_x, 4) && origin_z == $past(trans_z, 4)))
        else $error("translation lost its alignment with the word");

endmodule

FILE: hw/rtl/trsmc_quat_prod.sv
// First pipeline stage: the nine pairwise quaternion products.
module trsmc_quat_prod
    import trsmc_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  quat_t      quat_x,
    input  quat_t      quat_y,
    input  quat_t      quat_z,
    input  quat_t      quat_w,
    input  scale_vec_t scale_in,
    input  val_vec_t   trans_in,
    output quat_prod_t prod_reg,
    output scale_vec_t scale_reg,
    output val_vec_t   trans_reg
);

    quat_prod_t prod_next;

    always_comb
    begin
        prod_next.xx = PROD_W'(quat_x) * PROD_W'(quat_x);
        prod_next.yy = PROD_W'(quat_y) * PROD_W'(quat_y);
        prod_next.zz = PROD_W'(quat_z) * PROD_W'(quat_z);
        prod_next.xy = PROD_W'(quat_x) * PROD_W'(quat_y);
        prod_next.xz = PROD_W'(quat_x) * PROD_W'(quat_z);
        prod_next.yz = PROD_W'(quat_y) * PROD_W'(quat_z);
        prod_next.wx = PROD_W'(quat_w) * PROD_W'(quat_x);
        prod_next.wy = PROD_W'(quat_w) * PROD_W'(quat_y);
        prod_next.wz = PROD_W'(quat_w) * PROD_W'(quat_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            scale_reg <= scale_in;
            trans_reg <= trans_in;
        end
    end

endmodule

FILE: hw/rtl/trsmc_term.sv
// Second pipeline stage: the nine rotation terms from the quaternion products.
module trsmc_term
    import trsmc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEF
)
(
    input  logic                                           clk,
    input  logic                                           en,
    input  quat_prod_t                                     prod,
    input  scale_vec_t                                     scale_in,
    input  val_vec_t                                       trans_in,
    output logic signed [term_width(QUAT_FRAC_BITS)-1:0]   term_reg [NUM_TERMS],
    output scale_vec_t                                     scale_reg,
    output val_vec_t                                       trans_reg
);

    localparam int TW = term_width(QUAT_FRAC_BITS);

    logic signed [TW-1:0] one;
    logic signed [TW-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic signed [TW-1:0] term_next [NUM_TERMS];

    assign one  = TW'(1) <<< (2 * QUAT_FRAC_BITS);
    assign e_xx = TW'(prod.xx);
    assign e_yy = TW'(prod.yy);
    assign e_zz = TW'(prod.zz);
    assign e_xy = TW'(prod.xy);
    assign e_xz = TW'(prod.xz);
    assign e_yz = TW'(prod.yz);
    assign e_wx = TW'(prod.wx);
    assign e_wy = TW'(prod.wy);
    assign e_wz = TW'(prod.wz);

    always_comb
    begin
        term_next[IDX_XAXIS_X] = one - ((e_yy + e_zz) <<< 1);
        term_next[IDX_XAXIS_Y] = (e_xy + e_wz) <<< 1;
        term_next[IDX_XAXIS_Z] = (e_xz - e_wy) <<< 1;
        term_next[IDX_YAXIS_X] = (e_xy - e_wz) <<< 1;
        term_next[IDX_YAXIS_Y] = one - ((e_xx + e_zz) <<< 1);
        term_next[IDX_YAXIS_Z] = (e_yz + e_wx) <<< 1;
        term_next[IDX_ZAXIS_X] = (e_xz + e_wy) <<< 1;
        term_next[IDX_ZAXIS_Y] = (e_yz - e_wx) <<< 1;
        term_next[IDX_ZAXIS_Z] = one - ((e_xx + e_yy) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg  <= term_next;
            scale_reg <= scale_in;
            trans_reg <= trans_in;
        end
    end

endmodule

FILE: hw/rtl/trsmc_scale_mul.sv
// Third pipeline stage: each rotation term times the scale of its axis, kept exact.
module trsmc_scale_mul
    import trsmc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEF
)
(
    input  logic                                                   clk,
    input  logic                                                   en,
    input  logic signed [term_width(QUAT_FRAC_BITS)-1:0]           term [NUM_TERMS],
    input  scale_vec_t                                             scale_in,
    input  val_vec_t                                               trans_in,
    output logic signed [term_width(QUAT_FRAC_BITS)+SCALE_W-1:0]   prod_reg [NUM_TERMS],
    output val_vec_t                                               trans_reg
);

    localparam int TW = term_width(QUAT_FRAC_BITS);
    localparam int PW = TW + SCALE_W;

    logic signed [SCALE_W-1:0] axis_scale [NUM_AXES];
    logic signed [PW-1:0]      prod_next  [NUM_TERMS];

    assign axis_scale[0] = scale_in.x;
    assign axis_scale[1] = scale_in.y;
    assign axis_scale[2] = scale_in.z;

    for (genvar i = 0; i < NUM_TERMS; i++)
    begin : g_mul
        assign prod_next[i] = PW'(term[i]) * PW'(axis_scale[i / NUM_AXES]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_in;
        end
    end

endmodule

FILE: hw/rtl/trsmc_round_sat.sv
// Fourth pipeline stage: round to the output format, saturate, and hold the output word.
module trsmc_round_sat
    import trsmc_pkg::*;
#(
    parameter int QUAT_FRAC_BITS  = QUAT_FRAC_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_DEF
)
(
    input  logic                                                   clk,
    input  logic                                                   en,
    input  logic signed [term_width(QUAT_FRAC_BITS)+SCALE_W-1:0]   prod [NUM_TERMS],
    input  val_vec_t                                               trans_in,
    output val_t                                                   res_reg [NUM_TERMS],
    output val_vec_t                                               trans_reg
);

    localparam int TW = term_width(QUAT_FRAC_BITS);
    localparam int PW = TW + SCALE_W;
    localparam int SH = 2 * QUAT_FRAC_BITS + SCALE_FRAC_BITS - OUT_FRAC_BITS;

    val_t res_next [NUM_TERMS];

    for (genvar i = 0; i < NUM_TERMS; i++)
    begin : g_term
        logic            neg;
        logic [PW-1:0]   mag;
        logic [PW:0]     lim;
        logic [VAL_W-1:0] mag_out;

        assign neg = prod[i] < 0;
        assign mag = neg ? PW'(-prod[i]) : PW'(prod[i]);
        // The largest magnitude is 2^31 for negative results and 2^31-1 otherwise.
        assign lim = {{(PW + 1 - VAL_W){1'b0}}, neg, {(VAL_W - 1){~neg}}};

        if (SH > 0)
        begin : g_rnd
            logic [PW:0] rnd;
            logic [PW:0] shd;

            // Round half away from zero on the magnitude.
            assign rnd     = {1'b0, mag} + ((PW + 1)'(1) << (SH - 1));
            assign shd     = rnd >> SH;
            assign mag_out = (shd > lim) ? lim[VAL_W-1:0] : shd[VAL_W-1:0];
        end
        else
        begin : g_lsh
            localparam int K = -SH;

            assign mag_out = ({1'b0, mag} > (lim >> K)) ? lim[VAL_W-1:0]
                                                         : VAL_W'(mag << K);
        end

        assign res_next[i] = neg ? -mag_out : mag_out;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= res_next;
            trans_reg <= trans_in;
        end
    end

endmodule

FILE: dv/trs_matrix_compose_check.sv
// Checker for the TRS matrix compose block: predicts each result word and compares it.
`timescale 1ns / 1ps

module trs_matrix_compose_check
    import trsmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    input  logic                      in_stall,
    input  val_t                      trans_x,
    input  val_t                      trans_y,
    input  val_t                      trans_z,
    input  quat_t                     quat_x,
    input  quat_t                     quat_y,
    input  quat_t                     quat_z,
    input  quat_t                     quat_w,
    input  logic signed [SCALE_W-1:0] scale_x,
    input  logic signed [SCALE_W-1:0] scale_y,
    input  logic signed [SCALE_W-1:0] scale_z,

    input  logic                      out_valid,
    input  logic                      out_stall,
    input  val_t                      xaxis_x,
    input  val_t                      xaxis_y,
    input  val_t                      xaxis_z,
    input  val_t                      yaxis_x,
    input  val_t                      yaxis_y,
    input  val_t                      yaxis_z,
    input  val_t                      zaxis_x,
    input  val_t                      zaxis_y,
    input  val_t                      zaxis_z,
    input  val_t                      origin_x,
    input  val_t                      origin_y,
    input  val_t                      origin_z,

    output int                        mismatches,
    output int                        pending,
    output int                        checked
);

    typedef logic signed [SCALE_W-1:0] scale_t;

    localparam int IDX_ORIGIN_X = NUM_TERMS;
    localparam int IDX_ORIGIN_Y = NUM_TERMS + 1;
    localparam int IDX_ORIGIN_Z = NUM_TERMS + 2;
    localparam int NUM_ENTRIES  = NUM_TERMS + 3;

    // Fraction bits dropped between the exact scaled term and the output format.
    localparam int ROUND_SHIFT = 2 * QUAT_FRAC_DEF + SCALE_FRAC_DEF - OUT_FRAC_DEF;

    typedef logic [NUM_ENTRIES-1:0][VAL_W-1:0] matrix_t;

    matrix_t matrix_queue[$];
    matrix_t seen;
    int      fail_total  = 0;
    int      queue_depth = 0;
    int      match_total = 0;

    assign mismatches = fail_total;
    assign pending    = queue_depth;
    assign checked    = match_total;

    assign seen = {origin_z, origin_y, origin_x,
                   zaxis_z, zaxis_y, zaxis_x,
                   yaxis_z, yaxis_y, yaxis_x,
                   xaxis_z, xaxis_y, xaxis_x};

    // Rotation term times axis scale, rounded half away from zero and saturated.
    function automatic val_t scaled_entry(input longint term, input scale_t scl);
        logic [127:0]    mag;
        logic [127:0]    lim;
        longint unsigned tm;
        longint unsigned sm;
        bit              negative;
        negative = (term < 0) != (scl < 0);
        tm = (term < 0) ? -term : term;
        sm = (scl < 0) ? -longint'(scl) : longint'(scl);
        mag = 128'(tm) * 128'(sm);
        lim = negative ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (ROUND_SHIFT > 0)
        begin
            mag = (mag + (128'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            if (mag > lim)
                mag = lim;
        end
        else if (mag > (lim >> -ROUND_SHIFT))
            mag = lim;
        else
            mag = mag << -ROUND_SHIFT;
        return negative ? val_t'(-mag[31:0]) : val_t'(mag[31:0]);
    endfunction

    function automatic matrix_t compose(input val_t tx, input val_t ty, input val_t tz,
                                        input quat_t qx, input quat_t qy,
                                        input quat_t qz, input quat_t qw,
                                        input scale_t sx, input scale_t sy,
                                        input scale_t sz);
        longint  x, y, z, w, unit;
        longint  xx, yy, zz, xy, xz, yz, wx, wy, wz;
        matrix_t m;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        unit = longint'(1) << (2 * QUAT_FRAC_DEF);
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        m[IDX_XAXIS_X]  = scaled_entry(unit - 2 * (yy + zz), sx);
        m[IDX_XAXIS_Y]  = scaled_entry(2 * (xy + wz), sx);
        m[IDX_XAXIS_Z]  = scaled_entry(2 * (xz - wy), sx);
        m[IDX_YAXIS_X]  = scaled_entry(2 * (xy - wz), sy);
        m[IDX_YAXIS_Y]  = scaled_entry(unit - 2 * (xx + zz), sy);
        m[IDX_YAXIS_Z]  = scaled_entry(2 * (yz + wx), sy);
        m[IDX_ZAXIS_X]  = scaled_entry(2 * (xz + wy), sz);
        m[IDX_ZAXIS_Y]  = scaled_entry(2 * (yz - wx), sz);
        m[IDX_ZAXIS_Z]  = scaled_entry(unit - 2 * (xx + yy), sz);
        m[IDX_ORIGIN_X] = tx;
        m[IDX_ORIGIN_Y] = ty;
        m[IDX_ORIGIN_Z] = tz;
        return m;
    endfunction

    function automatic string entry_name(input int idx);
        case (idx)
            IDX_XAXIS_X:  return "xaxis_x";
            IDX_XAXIS_Y:  return "xaxis_y";
            IDX_XAXIS_Z:  return "xaxis_z";
            IDX_YAXIS_X:  return "yaxis_x";
            IDX_YAXIS_Y:  return "yaxis_y";
            IDX_YAXIS_Z:  return "yaxis_z";
            IDX_ZAXIS_X:  return "zaxis_x";
            IDX_ZAXIS_Y:  return "zaxis_y";
            IDX_ZAXIS_Z:  return "zaxis_z";
            IDX_ORIGIN_X: return "origin_x";
            IDX_ORIGIN_Y: return "origin_y";
            IDX_ORIGIN_Z: return "origin_z";
            default:      return "unknown";
        endcase
    endfunction

    always @(posedge clk)
    begin : monitor
        matrix_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                matrix_queue.push_back(compose(trans_x, trans_y, trans_z,
                                               quat_x, quat_y, quat_z, quat_w,
                                               scale_x, scale_y, scale_z));
            if (out_valid && !out_stall)
            begin
                if (matrix_queue.size() == 0)
                begin
                    $error("result word arrived with no prediction pending");
                    fail_total++;
                end
                else
                begin
                    want = matrix_queue.pop_front();
                    for (int i = 0; i < NUM_ENTRIES; i++)
                    begin
                        if (want[i] !== seen[i])
                        begin
                            $error("%s: expected %0d, got %0d", entry_name(i),
                                   $signed(want[i]), $signed(seen[i]));
                            fail_total++;
                        end
                    end
                    match_total++;
                end
            end
            queue_depth = matrix_queue.size();
        end
    end

endmodule

FILE: dv/trs_matrix_compose_top_test.sv
// Testbench top for the TRS matrix compose block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module trs_matrix_compose_top_test
    import trsmc_pkg::*;
();

    typedef logic signed [SCALE_W-1:0] scale_t;

    // One pose word as the sender offers it: translation, quaternion and scale.
    typedef struct packed {
        val_t   tx;
        val_t   ty;
        val_t   tz;
        quat_t  qx;
        quat_t  qy;
        quat_t  qz;
        quat_t  qw;
        scale_t sx;
        scale_t sy;
        scale_t sz;
    } pose_t;

    // Fixed-point ones and a few handy constants for directed words.
    localparam int          ONE_Q  = 1 << QUAT_FRAC_DEF;
    localparam int          ONE_S  = 1 << SCALE_FRAC_DEF;
    localparam int          SIN45  = 11585;
    localparam int          QMIN   = -32768;
    localparam int          QMAX   = 32767;
    localparam logic [31:0] TMIN   = 32'h8000_0000;
    localparam logic [31:0] TMAX   = 32'h7FFF_FFFF;

    // The pipeline is four stages deep; extra cycles at the end catch strays.
    localparam int DRAIN_CYCLES = 8;
    // Long receiver hold-off; far longer than the pipeline so the input must stall.
    localparam int HOLD_CYCLES  = 80;
    // Cycles with no word moving on either channel before the run is declared hung.
    // The longest legitimate quiet spell is the hold-off plus a short random gap.
    localparam int QUIET_LIMIT  = 1000;

    logic   clk = 1'b0;
    logic   rst_n;

    logic   in_valid;
    logic   in_stall;
    val_t   trans_x, trans_y, trans_z;
    quat_t  quat_x, quat_y, quat_z, quat_w;
    scale_t scale_x, scale_y, scale_z;

    logic   out_valid;
    logic   out_stall;
    val_t   xaxis_x, xaxis_y, xaxis_z;
    val_t   yaxis_x, yaxis_y, yaxis_z;
    val_t   zaxis_x, zaxis_y, zaxis_z;
    val_t   origin_x, origin_y, origin_z;

    int     mismatches;
    int     pending;
    int     checked;

    // Shared between stimulus and receiver: random idling on both sides, and the
    // number of long hold-offs asked of the receiver so far.
    bit     gaps_on       = 1'b1;
    int     holds_asked   = 0;
    int     holds_done    = 0;
    int     words_sent    = 0;
    int     quiet_cycles  = 0;

    always #6 clk = ~clk;

    trs_matrix_compose_top u_top (.*);

    trs_matrix_compose_check u_check (.*);

    // Build a pose word from plain numbers; translations are taken as raw bits.
    function automatic pose_t make_pose(input logic [31:0] tx, input logic [31:0] ty,
                                        input logic [31:0] tz,
                                        input int qx, input int qy, input int qz,
                                        input int qw,
                                        input int sx, input int sy, input int sz);
        pose_t p;
        p.tx = tx;
        p.ty = ty;
        p.tz = tz;
        p.qx = quat_t'(qx);
        p.qy = quat_t'(qy);
        p.qz = quat_t'(qz);
        p.qw = quat_t'(qw);
        p.sx = scale_t'(sx);
        p.sy = scale_t'(sy);
        p.sz = scale_t'(sz);
        return p;
    endfunction

    // Most random words look like real transforms: quaternion components within
    // about +/-1.0 and scales within +/-4.0. The rest use the full field range,
    // which pushes the products and the rounding to their widest.
    function automatic pose_t random_pose();
        pose_t p;
        bit    wide;
        wide = ($urandom_range(0, 99) < 30);
        p.tx = val_t'($urandom);
        p.ty = val_t'($urandom);
        p.tz = val_t'($urandom);
        if (wide)
        begin
            p.qx = quat_t'($urandom);
            p.qy = quat_t'($urandom);
            p.qz = quat_t'($urandom);
            p.qw = quat_t'($urandom);
            p.sx = scale_t'($urandom);
            p.sy = scale_t'($urandom);
            p.sz = scale_t'($urandom);
        end
        else
        begin
            p.qx = quat_t'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
            p.qy = quat_t'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
            p.qz = quat_t'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
            p.qw = quat_t'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
            p.sx = scale_t'(int'($urandom_range(0, 8 * ONE_S)) - 4 * ONE_S);
            p.sy = scale_t'(int'($urandom_range(0, 8 * ONE_S)) - 4 * ONE_S);
            p.sz = scale_t'(int'($urandom_range(0, 8 * ONE_S)) - 4 * ONE_S);
        end
        return p;
    endfunction

    // Offer one word. Inputs change only on the falling edge; the word is held
    // steady until a rising edge sees valid high and stall low.
    task automatic send_pose(input pose_t p);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        trans_x  = p.tx;
        trans_y  = p.ty;
        trans_z  = p.tz;
        quat_x   = p.qx;
        quat_y   = p.qy;
        quat_z   = p.qz;
        quat_w   = p.qw;
        scale_x  = p.sx;
        scale_y  = p.sy;
        scale_z  = p.sz;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // Drop valid on the next falling edge so the last word is not taken twice.
    task automatic rest_sender();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Receiver: random stalls while idling is on, and one long hold-off for each
    // one asked, counted here so the sender keeps offering words meanwhile.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall = gaps_on && ($urandom_range(0, 99) < 30);
        end
    end

    // Watchdog: a run where no word moves for too long is stuck.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d quiet cycles with %0d results pending.",
                     quiet_cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        pose_t directed[$];

        rst_n    = 1'b0;
        in_valid = 1'b0;
        trans_x  = '0;
        trans_y  = '0;
        trans_z  = '0;
        quat_x   = '0;
        quat_y   = '0;
        quat_z   = '0;
        quat_w   = '0;
        scale_x  = '0;
        scale_y  = '0;
        scale_z  = '0;

        // Identity rotation with unit scale and zero translation.
        directed.push_back(make_pose(0, 0, 0, 0, 0, 0, ONE_Q, ONE_S, ONE_S, ONE_S));
        // Everything zero.
        directed.push_back(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Every field at its most negative value.
        directed.push_back(make_pose(TMIN, TMIN, TMIN, QMIN, QMIN, QMIN, QMIN,
                                     QMIN, QMIN, QMIN));
        // Every field at its most positive value: the widest positive products.
        directed.push_back(make_pose(TMAX, TMAX, TMAX, QMAX, QMAX, QMAX, QMAX,
                                     QMAX, QMAX, QMAX));
        // Mixed extremes: quaternion and scale fields alternate in sign.
        directed.push_back(make_pose(TMAX, TMIN, 0, QMIN, QMAX, QMIN, QMAX,
                                     QMAX, QMIN, QMAX));
        // Quarter turns about each axis.
        directed.push_back(make_pose(0, 0, 0, SIN45, 0, 0, SIN45, ONE_S, ONE_S, ONE_S));
        directed.push_back(make_pose(0, 0, 0, 0, SIN45, 0, SIN45, ONE_S, ONE_S, ONE_S));
        directed.push_back(make_pose(0, 0, 0, 0, 0, SIN45, SIN45, ONE_S, ONE_S, ONE_S));
        // Half turn about x.
        directed.push_back(make_pose(0, 0, 0, ONE_Q, 0, 0, 0, ONE_S, ONE_S, ONE_S));
        // Off-diagonal products land exactly on half an output step, both signs,
        // so rounding must go away from zero.
        directed.push_back(make_pose(0, 0, 0, 128, 128, 0, 0, 16, -16, 16));
        // Just short of the half step: must round toward zero.
        directed.push_back(make_pose(0, 0, 0, 128, 128, 0, 0, 15, -15, 15));
        // A quaternion far from unit length; its stretch and skew must show up.
        directed.push_back(make_pose(0, 0, 0, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                                     ONE_S, ONE_S, ONE_S));
        // Mirroring scales with a quarter turn about z.
        directed.push_back(make_pose(0, 0, 0, 0, 0, SIN45, SIN45, -ONE_S, ONE_S, -ONE_S));
        // Alternating translation bit patterns pass straight through.
        directed.push_back(make_pose(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001,
                                     0, 0, 0, ONE_Q, ONE_S, ONE_S, ONE_S));
        // Smallest nonzero quaternion and scale magnitudes.
        directed.push_back(make_pose(32'h0000_0001, 32'hFFFF_FFFF, 0, -1, -1, -1, -1,
                                     1, -1, 1));
        // Zero scale with a skewed quaternion: all basis columns collapse.
        directed.push_back(make_pose(0, 0, 0, 12345, -23456, 321, -7, 0, 0, 0));

        // Reset once at the start; release it away from the rising edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_pose(directed[i]);

        // Random words with both sides idling at random.
        repeat (300) send_pose(random_pose());

        // A long stretch with no idling at all: one word per cycle each way.
        gaps_on = 1'b0;
        repeat (150) send_pose(random_pose());
        gaps_on = 1'b1;

        // The receiver holds off for a long time while words keep coming, so the
        // pipeline fills and the block has to stall its input.
        holds_asked++;
        repeat (100) send_pose(random_pose());

        // The sender pauses until every result is back, then resumes from an
        // empty pipeline.
        rest_sender();
        wait (pending == 0);
        repeat (200) send_pose(random_pose());

        rest_sender();
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pose words (directed extremes, quarter turns, rounding ties,",
                 words_sent);
        $display("  random content) and checked %0d result words; %0d long hold-off(s).",
                 checked, holds_done);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
